@@ sv/aes_pkg.sv @@
// Package: AES-128 types, S-box and round helper functions.
`default_nettype none
package aes_pkg;

	localparam int unsigned KeyWidth   = 64;
	localparam int unsigned BlockWidth = 128;
	localparam int unsigned NumRounds  = 10;
	localparam int unsigned IdxWidth   = 1;

	// configuration register indexes
	localparam logic [IdxWidth-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [IdxWidth-1:0] REG_KEY_LOW  = 1'b1;

	typedef struct packed {
		logic [63:0] plaintext_high;
		logic [63:0] plaintext_low;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] ciphertext_high;
		logic [63:0] ciphertext_low;
	} out_beat_t;

	typedef logic [BlockWidth-1:0] block_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// round constants, round 1 first
	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// byte i of a block sits in bits 127-8i .. 120-8i
	function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
		get_byte = b[BlockWidth-1-8*i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// next round key from the current one
	function automatic block_t next_key(input block_t k, input logic [7:0] rc);
		logic [7:0] kb [16];
		logic [7:0] t [4];
		block_t r;
		for (int i = 0; i < 16; i++) kb[i] = get_byte(k, i);
		t[0] = SBOX[kb[13]] ^ rc;
		t[1] = SBOX[kb[14]];
		t[2] = SBOX[kb[15]];
		t[3] = SBOX[kb[12]];
		for (int i = 0; i < 4; i++) kb[i] = kb[i] ^ t[i];
		for (int i = 4; i < 16; i++) kb[i] = kb[i] ^ kb[i-4];
		for (int i = 0; i < 16; i++) r[BlockWidth-1-8*i -: 8] = kb[i];
		next_key = r;
	endfunction

	// SubBytes, ShiftRows, optional MixColumns, AddRoundKey
	function automatic block_t enc_round(input block_t s, input block_t k,
			input logic do_mix);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		block_t r;
		for (int c = 0; c < 4; c++)
			for (int rr = 0; rr < 4; rr++)
				t[4*c+rr] = SBOX[get_byte(s, 4*((c+rr)%4)+rr)];
		if (do_mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[BlockWidth-1-8*i -: 8] = t[i];
		enc_round = r ^ k;
	endfunction

endpackage
`default_nettype wire

@@ sv/aes_round.sv @@
// One registered AES round stage with on-the-fly key expansion.
`default_nettype none
module aes_round #(
	parameter int unsigned RoundIdx = 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 vld,
	input  aes_pkg::block_t     state_in,
	input  aes_pkg::block_t     key_in,
	output logic                vld_s1,
	output aes_pkg::block_t     state_s1,
	output aes_pkg::block_t     key_s1
);
	localparam logic [7:0] Rc = aes_pkg::RCON[RoundIdx-1];
	localparam logic DoMix = (RoundIdx < aes_pkg::NumRounds);

	aes_pkg::block_t key_nx;

	// round key for this stage
	assign key_nx = aes_pkg::next_key(key_in, Rc);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= vld;
	end

	// data
	always_ff @(posedge clk) begin
		if (vld) begin
			key_s1   <= key_nx;
			state_s1 <= aes_pkg::enc_round(state_in, key_nx, DoMix);
		end
	end
endmodule
`default_nettype wire

@@ sv/aes128_block_encrypt.sv @@
// Top level: AES-128 encryptor, one round per pipeline stage.
//
// Usage:
//   Configuration: cfg_we, cfg_idx, cfg_data write key_high (index 0) or
//   key_low (index 1) at the clock edge; other indexes are ignored. Write
//   the key only while no block is in flight.
//   Input: a beat is taken at each edge where start is high and busy is
//   low. busy is always low, so a block may enter every cycle.
//   Output: done strobes for one cycle with the ciphertext on result.
//   Stages: one for the initial key add, one per round. Throughput: one
//   block per cycle, set by the ten unrolled round stages, each holding
//   one S-box layer; all but the last also hold MixColumns.
//   Reset: arst_n clears the key to zero and all stage valid bits, so no
//   stray done follows reset.
//   The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module aes128_block_encrypt (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [aes_pkg::IdxWidth-1:0]      cfg_idx,
	input  wire  [aes_pkg::KeyWidth-1:0]      cfg_data,
	input  wire                               start,
	output logic                              busy,
	input  aes_pkg::in_beat_t                 operand,
	output logic                              done,
	output aes_pkg::out_beat_t                result
);
	logic [aes_pkg::KeyWidth-1:0] key_hi_q, key_lo_q;
	logic             vld [aes_pkg::NumRounds+1];
	aes_pkg::block_t  st  [aes_pkg::NumRounds+1];
	aes_pkg::block_t  ky  [aes_pkg::NumRounds+1];

	assign busy = 1'b0;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				aes_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data;
				aes_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 0: initial AddRoundKey
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld[0] <= 1'b0;
		else vld[0] <= start;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st[0] <= {operand.plaintext_high, operand.plaintext_low}
				^ {key_hi_q, key_lo_q};
			ky[0] <= {key_hi_q, key_lo_q};
		end
	end

	// round stages
	for (genvar r = 1; r <= aes_pkg::NumRounds; r++) begin : g_round
		aes_round #(.RoundIdx(r)) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld      (vld[r-1]),
			.state_in (st[r-1]),
			.key_in   (ky[r-1]),
			.vld_s1   (vld[r]),
			.state_s1 (st[r]),
			.key_s1   (ky[r])
		);
	end

	assign done = vld[aes_pkg::NumRounds];
	assign result.ciphertext_high = st[aes_pkg::NumRounds][127:64];
	assign result.ciphertext_low  = st[aes_pkg::NumRounds][63:0];
endmodule
`default_nettype wire

@@ sv/aes_chk.sv @@
// Port-level checker for the AES-128 encryptor, bound to the top level.
`default_nettype none
module aes_chk (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done
);
	localparam int unsigned Lat = aes_pkg::NumRounds + 1;

	// every accepted block gives done after fixed latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Lat done) else $error("missing done");

	// no done without a block accepted earlier
	a_nospur: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Lat)) else $error("spurious done");

	// pipeline never refuses input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy asserted");
endmodule

bind aes128_block_encrypt aes_chk u_aes_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
`default_nettype wire

@@ bench/tb_aes128_block_encrypt.sv @@
// Testbench: AES-128 encryptor checked against a behavioral cipher model.
`default_nettype none
module tb_aes128_block_encrypt;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [aes_pkg::IdxWidth-1:0] cfg_idx = aes_pkg::REG_KEY_HIGH;
	logic [aes_pkg::KeyWidth-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	aes_pkg::in_beat_t operand = '0;
	logic done;
	aes_pkg::out_beat_t result;

	aes128_block_encrypt uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .start(start), .busy(busy), .operand(operand),
		.done(done), .result(result)
	);

	always #4 clk = ~clk;

	// forward S-box built from GF(2^8) inverse and the affine map
	logic [7:0] sub_table [256];
	logic [63:0] key_hi, key_lo;
	aes_pkg::in_beat_t pending_blocks [$];
	aes_pkg::out_beat_t cipher_expected [$];
	int errors = 0;
	int send_idle_pct = 0;

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic build_sub_table();
		logic [7:0] inv, y;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int c = 1; c < 256; c++)
				if (x != 0 && gmul(x[7:0], c[7:0]) == 8'h01) inv = c[7:0];
			y = 8'h63;
			for (int b = 0; b < 8; b++)
				y[b] = y[b] ^ inv[b] ^ inv[(b+4)%8] ^ inv[(b+5)%8]
					^ inv[(b+6)%8] ^ inv[(b+7)%8];
			sub_table[x] = y;
		end
	endtask

	// full ten-round encryption of one block under the current key
	function automatic aes_pkg::out_beat_t encrypt_block(input aes_pkg::in_beat_t pt);
		logic [7:0] st [16], rk [16], tmp [16], tw [4];
		logic [7:0] rc, a0, a1, a2, a3, al;
		logic [127:0] ptv, kv, ov;
		ptv = pt;
		kv = {key_hi, key_lo};
		for (int i = 0; i < 16; i++) begin
			st[i] = ptv[127-8*i -: 8];
			rk[i] = kv[127-8*i -: 8];
			st[i] ^= rk[i];
		end
		rc = 8'h01;
		for (int rnd = 1; rnd <= 10; rnd++) begin
			tw[0] = sub_table[rk[13]] ^ rc;
			tw[1] = sub_table[rk[14]];
			tw[2] = sub_table[rk[15]];
			tw[3] = sub_table[rk[12]];
			for (int i = 0; i < 4; i++) rk[i] ^= tw[i];
			for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
			rc = dbl(rc);
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[4*c+r] = sub_table[st[4*((c+r)%4)+r]];
			if (rnd < 10)
				for (int c = 0; c < 4; c++) begin
					a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					tmp[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
					tmp[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
					tmp[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
					tmp[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
				end
			for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++) ov[127-8*i -: 8] = st[i];
		return ov;
	endfunction

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// driver: one beat per accepted edge, random idle per phase
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				cipher_expected.push_back(encrypt_block(operand));
				void'(pending_blocks.pop_front());
			end
			if (pending_blocks.size() > 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				start <= 1'b1;
				operand <= pending_blocks[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each ciphertext beat with the oldest expectation
	always @(posedge clk) begin
		aes_pkg::out_beat_t exp_ct;
		if (arst_n && done) begin
			if (cipher_expected.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, result);
				errors++;
			end else begin
				exp_ct = cipher_expected.pop_front();
				if (result.ciphertext_high !== exp_ct.ciphertext_high) begin
					$display("%0t: ciphertext_high exp %h got %h", $time,
						exp_ct.ciphertext_high, result.ciphertext_high);
					errors++;
				end
				if (result.ciphertext_low !== exp_ct.ciphertext_low) begin
					$display("%0t: ciphertext_low exp %h got %h", $time,
						exp_ct.ciphertext_low, result.ciphertext_low);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic [aes_pkg::IdxWidth-1:0] idx,
			input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == aes_pkg::REG_KEY_HIGH) key_hi = val;
		else key_lo = val;
	endtask

	task automatic drain();
		while (pending_blocks.size() != 0 || start || cipher_expected.size() != 0)
			@(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
		aes_pkg::in_beat_t b;
		b.plaintext_high = hi;
		b.plaintext_low = lo;
		pending_blocks.push_back(b);
	endtask

	initial begin
		int idle_set [4] = '{0, 63, 0, 11};
		key_hi = '0;
		key_lo = '0;
		build_sub_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// zero key after reset, extreme plaintexts
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block(64'h8000000000000000, 64'h1);
		drain();
		// standard test vector key
		write_reg(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
		write_reg(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		queue_block('0, '1);
		queue_block('1, '0);
		drain();
		write_reg(aes_pkg::REG_KEY_HIGH, '1);
		write_reg(aes_pkg::REG_KEY_LOW, '1);
		queue_block('0, '0);
		queue_block('1, '1);
		queue_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		drain();
		// random phases with differing idle rates and keys
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(aes_pkg::REG_KEY_HIGH, rand64());
			write_reg(aes_pkg::REG_KEY_LOW, rand64());
			send_idle_pct = idle_set[ph % 4];
			for (int i = 0; i < 105; i++) queue_block(rand64(), rand64());
			drain();
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

@@ aes128_block_encrypt.f @@
sv/aes_pkg.sv
sv/aes_round.sv
sv/aes128_block_encrypt.sv
sv/aes_chk.sv
bench/tb_aes128_block_encrypt.sv
